/* rtl/scale_degree_converter_core_defines.svh */
// Assertion macros for the scale degree converter.
// Used by scale_degree_converter_core; expects signals clock and reset in scope.
`ifndef SCALE_DEGREE_CONVERTER_CORE_DEFINES_SVH
`define SCALE_DEGREE_CONVERTER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SDC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sdc_pkg.sv */
// Shared types and constants of the scale degree converter.
// No dependencies.
package sdc_pkg;

   localparam int KIND_W    = 1;
   localparam int ROOT_W    = 7;
   localparam int VAL_W     = 10;
   localparam int OUT_W     = 16;
   localparam int LEN_W     = 6;
   localparam int WORD_W    = 64;
   localparam int ENTRY_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CNT_W     = 6;
   localparam int DIV_STEPS = VAL_W;
   localparam int SEMIS     = 12;

   localparam logic [LEN_W-1:0]  LEN_RESET = 6'd7;
   localparam logic [WORD_W-1:0] LOW_RESET = 64'd194466848;
   localparam logic [WORD_W-1:0] HIGH_RESET = 64'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LENGTH       = 2'd0,
      REG_ENTRIES_LOW  = 2'd1,
      REG_ENTRIES_HIGH = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

/* rtl/sdc_req_if.sv */
// Request channel of the scale degree converter: valid/ready plus payload.
// Depends on sdc_pkg for field widths.
interface sdc_req_if;
   logic                              valid;
   logic                              ready;
   logic [sdc_pkg::KIND_W-1:0]        kind;
   logic [sdc_pkg::ROOT_W-1:0]        root_note;
   logic signed [sdc_pkg::VAL_W-1:0]  note_or_degree;
   logic signed [sdc_pkg::VAL_W-1:0]  fallback_degree;

   modport source (output valid, kind, root_note, note_or_degree, fallback_degree,
                   input ready);
   modport sink   (input valid, kind, root_note, note_or_degree, fallback_degree,
                   output ready);
endinterface

/* rtl/sdc_rsp_if.sv */
// Response channel of the scale degree converter: valid/ready plus payload.
// Depends on sdc_pkg for field widths.
interface sdc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [sdc_pkg::OUT_W-1:0]  converted;
   logic                              matched;

   modport source (output valid, converted, matched, input ready);
   modport sink   (input valid, converted, matched, output ready);
endinterface

/* rtl/scale_degree_converter_core.sv */
// Scale degree converter: note number <-> one-based scale degree.
// Depends on sdc_pkg, sdc_req_if, sdc_rsp_if and the assertion macro header.
//
// One request at a time. A request is taken only when the converter is idle;
// the response sits in an output register, so the next request can be taken
// while it waits. Both directions run the 10-step restoring divider (by 12
// or by the scale length) and a correction step; note-to-degree then runs
// the scale search, which checks one entry a cycle and stops at the first
// matching scale entry or after the last entry of the scale. The done state
// forms the result with one small shared multiplier.
`include "scale_degree_converter_core_defines.svh"

module scale_degree_converter_core #(
   parameter int MAX_SCALE_LEN = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sdc_req_if.sink                              req_ch,
   sdc_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [sdc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sdc_pkg::WORD_W-1:0]           csr_wdata
);

   localparam logic [sdc_pkg::LEN_W-1:0] LEN_MAX = sdc_pkg::LEN_W'(MAX_SCALE_LEN);

   function automatic logic [sdc_pkg::ENTRY_W-1:0] entry_at(
      input logic [sdc_pkg::WORD_W-1:0] lo,
      input logic [sdc_pkg::WORD_W-1:0] hi,
      input logic [4:0]                 idx
   );
      logic [sdc_pkg::WORD_W-1:0] word;
      word = idx[4] ? hi : lo;
      return word[{idx[3:0], 2'b00} +: sdc_pkg::ENTRY_W];
   endfunction

   // configuration
   logic [sdc_pkg::LEN_W-1:0]  len_ff;
   logic [sdc_pkg::WORD_W-1:0] lo_ff;
   logic [sdc_pkg::WORD_W-1:0] hi_ff;
   logic [sdc_pkg::LEN_W-1:0]  len_eff;

   // sequencer and datapath
   sdc_pkg::state_type          state_ff, state_in;
   logic                        kind_ff, kind_in;
   logic [sdc_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [sdc_pkg::VAL_W-1:0]   fb_ff, fb_in;
   logic                        neg_ff, neg_in;
   logic [sdc_pkg::VAL_W-1:0]   dq_ff, dq_in;
   logic [5:0]                  rem_ff, rem_in;
   logic [5:0]                  dvs_ff, dvs_in;
   logic [sdc_pkg::VAL_W:0]     oct_ff, oct_in;
   logic [4:0]                  pos_ff, pos_in;
   logic [sdc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        hit_ff, hit_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sdc_pkg::OUT_W-1:0]   conv_ff, conv_in;
   logic                        match_ff, match_in;

   // combinational helpers
   logic [sdc_pkg::VAL_W:0]     diff;
   logic [sdc_pkg::VAL_W:0]     sub_rhs;
   logic [6:0]                  trial;
   logic                        ge;
   logic [5:0]                  factor;
   logic signed [17:0]          prod;
   logic [7:0]                  addend;
   logic [17:0]                 sum;
   logic                        req_take;
   logic                        rsp_free;

   always_comb begin
      len_eff = len_ff;
      if (len_ff == '0) begin
         len_eff = sdc_pkg::LEN_W'(1);
      end else if (len_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= sdc_pkg::LEN_RESET;
         lo_ff  <= sdc_pkg::LOW_RESET;
         hi_ff  <= sdc_pkg::HIGH_RESET;
      end else if (csr_we) begin
         unique case (sdc_pkg::reg_index_type'(csr_index))
            sdc_pkg::REG_LENGTH: begin
               len_ff <= csr_wdata[sdc_pkg::LEN_W-1:0];
            end
            sdc_pkg::REG_ENTRIES_LOW: begin
               lo_ff <= csr_wdata;
            end
            sdc_pkg::REG_ENTRIES_HIGH: begin
               hi_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign req_ch.ready = (state_ff == sdc_pkg::ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign sub_rhs = req_ch.kind ? (sdc_pkg::VAL_W+1)'(1)
                                : {4'd0, req_ch.root_note};
   assign diff    = {req_ch.note_or_degree[sdc_pkg::VAL_W-1], req_ch.note_or_degree}
                    - sub_rhs;

   assign trial = {rem_ff, dq_ff[sdc_pkg::VAL_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});

   assign factor = kind_ff ? 6'(sdc_pkg::SEMIS) : len_eff;
   assign prod   = $signed(oct_ff) * $signed({1'b0, factor});
   assign addend = kind_ff ? ({1'b0, root_ff} + {4'd0, entry_at(lo_ff, hi_ff, pos_ff)})
                           : ({2'd0, cnt_ff} + 8'd1);
   assign sum    = 18'(prod) + {10'd0, addend};

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      root_in      = root_ff;
      fb_in        = fb_ff;
      neg_in       = neg_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      oct_in       = oct_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      conv_in      = conv_ff;
      match_in     = match_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         sdc_pkg::ST_IDLE: begin
            if (req_take) begin
               kind_in  = req_ch.kind;
               root_in  = req_ch.root_note;
               fb_in    = req_ch.fallback_degree;
               neg_in   = diff[sdc_pkg::VAL_W];
               dq_in    = diff[sdc_pkg::VAL_W] ? ~diff[sdc_pkg::VAL_W-1:0]
                                               : diff[sdc_pkg::VAL_W-1:0];
               rem_in   = '0;
               dvs_in   = req_ch.kind ? len_eff : 6'(sdc_pkg::SEMIS);
               cnt_in   = '0;
               state_in = sdc_pkg::ST_DIV;
            end
         end
         sdc_pkg::ST_DIV: begin
            rem_in = ge ? 6'(trial - {1'b0, dvs_ff}) : trial[5:0];
            dq_in  = {dq_ff[sdc_pkg::VAL_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sdc_pkg::CNT_W'(sdc_pkg::DIV_STEPS - 1)) begin
               state_in = sdc_pkg::ST_FIX;
            end
         end
         sdc_pkg::ST_FIX: begin
            // floor correction for negative dividends
            oct_in = neg_ff ? ~{1'b0, dq_ff} : {1'b0, dq_ff};
            if (kind_ff) begin
               pos_in   = neg_ff ? 5'(len_eff - 6'd1 - rem_ff) : rem_ff[4:0];
               hit_in   = 1'b1;
               state_in = sdc_pkg::ST_DONE;
            end else begin
               pos_in   = neg_ff ? 5'(sdc_pkg::SEMIS - 1) - rem_ff[4:0] : rem_ff[4:0];
               hit_in   = 1'b0;
               cnt_in   = '0;
               state_in = sdc_pkg::ST_SCAN;
            end
         end
         sdc_pkg::ST_SCAN: begin
            if ({1'b0, entry_at(lo_ff, hi_ff, cnt_ff[4:0])} == pos_ff) begin
               hit_in   = 1'b1;
               state_in = sdc_pkg::ST_DONE;
            end else if (cnt_ff == len_eff - 6'd1) begin
               state_in = sdc_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         sdc_pkg::ST_DONE: begin
            if (rsp_free) begin
               conv_in      = hit_ff ? sum[sdc_pkg::OUT_W-1:0]
                                     : {{(sdc_pkg::OUT_W-sdc_pkg::VAL_W){fb_ff[sdc_pkg::VAL_W-1]}},
                                        fb_ff};
               match_in     = hit_ff;
               rsp_valid_in = 1'b1;
               state_in     = sdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      root_ff  <= root_in;
      fb_ff    <= fb_in;
      neg_ff   <= neg_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      oct_ff   <= oct_in;
      pos_ff   <= pos_in;
      cnt_ff   <= cnt_in;
      hit_ff   <= hit_in;
      conv_ff  <= conv_in;
      match_ff <= match_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.converted = conv_ff;
   assign rsp_ch.matched   = match_ff;

   `SDC_ASSERT_NEXT(a_take_starts_div, req_take, state_ff == sdc_pkg::ST_DIV, "request not sent to divider")
   `SDC_ASSERT_NEXT(a_div_length, (state_ff == sdc_pkg::ST_DIV) && (cnt_ff == sdc_pkg::CNT_W'(sdc_pkg::DIV_STEPS - 1)), state_ff == sdc_pkg::ST_FIX, "divider step count wrong")
   `SDC_ASSERT_NOW(a_rem_below_divisor, state_ff == sdc_pkg::ST_FIX, rem_ff < dvs_ff, "remainder not below divisor")
   `SDC_ASSERT_NOW(a_scan_in_range, state_ff == sdc_pkg::ST_SCAN, cnt_ff < len_eff, "scan index past scale length")

endmodule

/* sim/tb_scale_degree_converter_core.sv */
// Testbench for scale_degree_converter_core: directed and random note/degree requests,
// each result checked against a built-in conversion predictor, under random idling.
// Depends on sdc_pkg, sdc_req_if, sdc_rsp_if and the converter RTL.
module tb_scale_degree_converter_core;

   localparam logic KIND_TO_DEGREE = 1'b0;
   localparam logic KIND_TO_NOTE   = 1'b1;
   localparam logic [sdc_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int MAX_LEN = 32;
   localparam int NIBBLES = 16;

   typedef struct packed {
      logic signed [sdc_pkg::OUT_W-1:0] converted;
      logic                             matched;
   } conversion_type;

   logic clock = 1'b0;
   logic reset;
   logic                          csr_we;
   logic [sdc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sdc_pkg::WORD_W-1:0]    csr_wdata;

   sdc_req_if req_bus ();
   sdc_rsp_if rsp_bus ();

   scale_degree_converter_core #(.MAX_SCALE_LEN(MAX_LEN)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [sdc_pkg::LEN_W-1:0]  scale_len_copy;
   logic [sdc_pkg::WORD_W-1:0] scale_low_copy;
   logic [sdc_pkg::WORD_W-1:0] scale_high_copy;

   conversion_type pending_conversions[$];
   int error_count = 0;
   int mismatch_count = 0;
   int rsp_hold_cycles = 0;
   bit steady_flow = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int floor_quot(int a, int b);
      int q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0)))
         q--;
      return q;
   endfunction

   function automatic int scale_entry(int i);
      if (i < NIBBLES)
         return int'(scale_low_copy[4*i +: 4]);
      return int'(scale_high_copy[4*(i-NIBBLES) +: 4]);
   endfunction

   function automatic conversion_type predict_conversion(
      logic kind, logic [sdc_pkg::ROOT_W-1:0] root,
      logic signed [sdc_pkg::VAL_W-1:0] val,
      logic signed [sdc_pkg::VAL_W-1:0] fallback);
      int len, diff, oct, off, idx, res;
      logic hit;
      conversion_type r;
      len = int'(scale_len_copy);
      if (len == 0)
         len = 1;
      if (len > MAX_LEN)
         len = MAX_LEN;
      res = int'(fallback);
      hit = 1'b0;
      if (kind == KIND_TO_DEGREE) begin
         diff = int'(val) - int'(root);
         oct = floor_quot(diff, sdc_pkg::SEMIS);
         off = diff - oct * sdc_pkg::SEMIS;
         for (int i = 0; i < len; i++) begin
            if (!hit && scale_entry(i) == off) begin
               res = oct * len + i + 1;
               hit = 1'b1;
            end
         end
      end else begin
         diff = int'(val) - 1;
         oct = floor_quot(diff, len);
         idx = diff - oct * len;
         res = int'(root) + oct * sdc_pkg::SEMIS + scale_entry(idx);
         hit = 1'b1;
      end
      r.converted = res[sdc_pkg::OUT_W-1:0];
      r.matched = hit;
      return r;
   endfunction

   // all tasks below are entered and left at a falling edge
   task automatic send_request(logic kind, logic [sdc_pkg::ROOT_W-1:0] root,
                               logic signed [sdc_pkg::VAL_W-1:0] val,
                               logic signed [sdc_pkg::VAL_W-1:0] fallback);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.kind = kind;
      req_bus.root_note = root;
      req_bus.note_or_degree = val;
      req_bus.fallback_degree = fallback;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_conversions.push_back(predict_conversion(kind, root, val, fallback));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_conversions.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [sdc_pkg::CSR_IDX_W-1:0] idx,
                            logic [sdc_pkg::WORD_W-1:0] data);
      req_bus.valid = 1'b0;
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         sdc_pkg::REG_LENGTH:       scale_len_copy = data[sdc_pkg::LEN_W-1:0];
         sdc_pkg::REG_ENTRIES_LOW:  scale_low_copy = data;
         sdc_pkg::REG_ENTRIES_HIGH: scale_high_copy = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [sdc_pkg::WORD_W-1:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [sdc_pkg::WORD_W-1:0] random_scale_word();
      logic [sdc_pkg::WORD_W-1:0] w;
      for (int i = 0; i < NIBBLES; i++)
         w[4*i +: 4] = 4'($urandom_range(0, sdc_pkg::SEMIS - 1));
      return w;
   endfunction

   task automatic test_reset_scale();
      send_request(KIND_TO_DEGREE, 7'd60, 10'sd60, 10'sd0);
      send_request(KIND_TO_DEGREE, 7'd60, 10'sd61, -10'sd512);
      send_request(KIND_TO_DEGREE, 7'd60, 10'sd66, 10'sd511);
      send_request(KIND_TO_DEGREE, 7'd0, -10'sd512, 10'sd511);
      send_request(KIND_TO_DEGREE, 7'd127, 10'sd511, -10'sd512);
      send_request(KIND_TO_DEGREE, 7'd127, -10'sd512, 10'sd3);
      send_request(KIND_TO_NOTE, 7'd0, -10'sd512, 10'sd0);
      send_request(KIND_TO_NOTE, 7'd127, 10'sd511, 10'sd0);
      send_request(KIND_TO_NOTE, 7'd60, 10'sd0, 10'sd0);
      send_request(KIND_TO_NOTE, 7'd60, 10'sd8, -10'sd1);
      wait_drained();
   endtask

   task automatic test_length_limits();
      write_csr(sdc_pkg::REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0);
      send_request(KIND_TO_NOTE, 7'd60, 10'sd5, 10'sd0);
      send_request(KIND_TO_DEGREE, 7'd60, 10'sd72, 10'sd9);
      wait_drained();
      write_csr(sdc_pkg::REG_ENTRIES_HIGH, random_scale_word());
      write_csr(sdc_pkg::REG_LENGTH, 64'd63);
      send_request(KIND_TO_NOTE, 7'd10, 10'sd33, 10'sd0);
      send_request(KIND_TO_DEGREE, 7'd10, 10'sd200, 10'sd1);
      wait_drained();
      write_csr(sdc_pkg::REG_LENGTH, 64'd33);
      send_request(KIND_TO_NOTE, 7'd10, 10'sd64, 10'sd0);
      wait_drained();
      write_csr(sdc_pkg::REG_LENGTH, 64'd32);
      send_request(KIND_TO_NOTE, 7'd127, -10'sd512, 10'sd0);
      wait_drained();
   endtask

   task automatic test_high_offsets();
      write_csr(sdc_pkg::REG_ENTRIES_LOW, 64'hFEDC_BA98_7654_3210);
      write_csr(sdc_pkg::REG_LENGTH, 64'd16);
      send_request(KIND_TO_DEGREE, 7'd0, 10'sd5, 10'sd0);
      send_request(KIND_TO_DEGREE, 7'd0, 10'sd11, 10'sd0);
      send_request(KIND_TO_NOTE, 7'd0, 10'sd13, 10'sd0);
      send_request(KIND_TO_NOTE, 7'd0, 10'sd16, 10'sd0);
      wait_drained();
      write_csr(sdc_pkg::REG_ENTRIES_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(sdc_pkg::REG_ENTRIES_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(sdc_pkg::REG_LENGTH, 64'd32);
      send_request(KIND_TO_DEGREE, 7'd20, 10'sd35, -10'sd7);
      send_request(KIND_TO_NOTE, 7'd20, 10'sd32, 10'sd0);
      wait_drained();
   endtask

   task automatic test_ignored_index();
      write_csr(REG_UNUSED, random_word());
      send_request(KIND_TO_DEGREE, 7'd20, 10'sd47, 10'sd2);
      send_request(KIND_TO_NOTE, 7'd20, 10'sd3, 10'sd0);
      wait_drained();
   endtask

   task automatic test_back_pressure();
      write_csr(sdc_pkg::REG_ENTRIES_LOW, random_scale_word());
      write_csr(sdc_pkg::REG_LENGTH, 64'd12);
      steady_flow = 1'b1;
      rsp_hold_cycles = 200;
      for (int i = 0; i < 12; i++)
         send_request(1'($urandom()), 7'($urandom()), 10'($urandom()), 10'($urandom()));
      steady_flow = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_conversions(int phases, int per_phase);
      logic [sdc_pkg::WORD_W-1:0] len_word;
      logic kind;
      logic [sdc_pkg::ROOT_W-1:0] root;
      logic signed [sdc_pkg::VAL_W-1:0] val;
      int t, len;
      for (int p = 0; p < phases; p++) begin
         wait_drained();
         len_word = random_word();
         case ($urandom_range(0, 3))
            0: len_word[sdc_pkg::LEN_W-1:0] = 6'($urandom_range(1, 7));
            1: len_word[sdc_pkg::LEN_W-1:0] = 6'($urandom_range(1, MAX_LEN));
            2: len_word[sdc_pkg::LEN_W-1:0] = 6'($urandom_range(MAX_LEN, 63));
            default: ;
         endcase
         if (p == 1)
            len_word[sdc_pkg::LEN_W-1:0] = '0;
         write_csr(sdc_pkg::REG_LENGTH, len_word);
         write_csr(sdc_pkg::REG_ENTRIES_LOW, ($urandom_range(0, 2) == 0) ? random_word()
                                                                         : random_scale_word());
         write_csr(sdc_pkg::REG_ENTRIES_HIGH, ($urandom_range(0, 2) == 0) ? random_word()
                                                                          : random_scale_word());
         if ($urandom_range(0, 3) == 0)
            write_csr(REG_UNUSED, random_word());
         len = int'(scale_len_copy);
         if (len == 0)
            len = 1;
         if (len > MAX_LEN)
            len = MAX_LEN;
         steady_flow = (p % 5 == 0);
         for (int i = 0; i < per_phase; i++) begin
            kind = 1'($urandom());
            root = 7'($urandom());
            case ($urandom_range(0, 4))
               0, 1: val = 10'($urandom());
               2: begin
                  t = int'(root) + $urandom_range(0, 80) - 40;
                  val = t[sdc_pkg::VAL_W-1:0];
               end
               3: begin
                  t = (kind == KIND_TO_NOTE) ? $urandom_range(0, 3 * len) - len
                                             : int'(root) + $urandom_range(0, 24) - 12;
                  val = t[sdc_pkg::VAL_W-1:0];
               end
               default: val = $urandom_range(0, 1) ? 10'sd511 : -10'sd512;
            endcase
            send_request(kind, root, val, 10'($urandom()));
            if ($urandom_range(0, 49) == 0)
               wait_drained();
         end
      end
      steady_flow = 1'b0;
      wait_drained();
   endtask

   // response side: random ready, long hold-off on request, result check
   initial begin
      int gap;
      conversion_type want;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         gap = steady_flow ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         if (pending_conversions.size() == 0) begin
            error_count++;
            if (mismatch_count < 10)
               $display("unexpected result: converted %0d matched %0d",
                        rsp_bus.converted, rsp_bus.matched);
            mismatch_count++;
         end else begin
            want = pending_conversions.pop_front();
            if (rsp_bus.converted !== want.converted ||
                rsp_bus.matched !== want.matched) begin
               error_count++;
               if (mismatch_count < 10)
                  $display("mismatch: expected converted %0d matched %0d, got %0d %0d",
                           want.converted, want.matched, rsp_bus.converted, rsp_bus.matched);
               mismatch_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = '0;
      req_bus.root_note = '0;
      req_bus.note_or_degree = '0;
      req_bus.fallback_degree = '0;
      scale_len_copy = sdc_pkg::LEN_RESET;
      scale_low_copy = sdc_pkg::LOW_RESET;
      scale_high_copy = sdc_pkg::HIGH_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_reset_scale();
      test_length_limits();
      test_high_offsets();
      test_ignored_index();
      test_back_pressure();
      test_random_conversions(16, 100);
      repeat (20) @(negedge clock);
      error_count += pending_conversions.size();
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
